### hdl/pixel_color_space_converter_unit_assert.svh
// ----------------------------------------------------------------------------
// pixel color space converter assertion macros
// shared property forms for the converter's checker
// ----------------------------------------------------------------------------
`ifndef PIXEL_COLOR_SPACE_CONVERTER_UNIT_ASSERT_SVH
`define PIXEL_COLOR_SPACE_CONVERTER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PCSC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcsc: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PCSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcsc: next-cycle check failed");

`endif

### hdl/pcsc_pkg.sv
// ----------------------------------------------------------------------------
// pcsc_pkg
// mode codes and coefficient helper for the pixel color space converter
// ----------------------------------------------------------------------------
package pcsc_pkg;

   typedef enum logic [1:0] {
      MODE_RGB2YUV  = 2'd0,
      MODE_YUV2RGB  = 2'd1,
      MODE_RGB2GRAY = 2'd2,
      MODE_GRAY_REP = 2'd3
   } mode_type;

   // constant in thousandths to unsigned fixed point, rounded half up
   function automatic longint coef_q(input longint milli, input int frac);
      return ((milli << frac) + 64'sd500) / 64'sd1000;
   endfunction

endpackage

### hdl/pixel_color_space_converter_unit.sv
// ----------------------------------------------------------------------------
// pixel_color_space_converter_unit
// streaming pixel converter: rgb/yuv (bt601), gray and gray replicate
// ----------------------------------------------------------------------------
// One 32-bit pixel per beat, one result beat per pixel, in order. The mode
// register selects rgb to yuv (alpha kept, packed a,y,u,v from the top byte
// down), yuv to rgb (a,b,g,r, clamped to 0..255), rgb to gray (gray in byte 0,
// upper bytes zero) or gray replicate (byte 0 copied to all bytes). A pixel
// passes through three registers: an input register, a product register
// holding nine constant-coefficient products, and the result register where
// the channel sums are truncated and clamped. A new pixel is taken every
// clock while the output side keeps up, and each stage fills a bubble on
// its own when the output stalls. Coefficients are fixed point with
// COEF_FRAC_BITS fraction bits (8..24). Write the mode only while no pixel
// is in flight.
// ----------------------------------------------------------------------------
module pixel_color_space_converter_unit #(
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_wr_en,
   input  pcsc_pkg::mode_type csr_wr_data,
   // pixel input
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,   // pixel_in[31:0]
   input  logic               req_tlast,   // last_in
   // converted output
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,   // pixel_out[31:0]
   output logic               rsp_tlast    // last_out
);
   import pcsc_pkg::*;

   localparam int FB = COEF_FRAC_BITS;
   // signed coefficient width: largest is 1.770 in fixed point plus sign
   localparam int CW = FB + 2;
   // signed sum width: every channel sum stays below 2^(FB+10) in magnitude
   localparam int SW = FB + 11;

   typedef logic signed [CW-1:0] coef_type;
   typedef logic signed [SW-1:0] sum_type;

   localparam coef_type C_299  = CW'(coef_q(299, FB));
   localparam coef_type C_587  = CW'(coef_q(587, FB));
   localparam coef_type C_114  = CW'(coef_q(114, FB));
   localparam coef_type C_N169 = -CW'(coef_q(169, FB));
   localparam coef_type C_N331 = -CW'(coef_q(331, FB));
   localparam coef_type C_500  = CW'(coef_q(500, FB));
   localparam coef_type C_N419 = -CW'(coef_q(419, FB));
   localparam coef_type C_N081 = -CW'(coef_q(81, FB));
   localparam coef_type C_1403 = CW'(coef_q(1403, FB));
   localparam coef_type C_N343 = -CW'(coef_q(343, FB));
   localparam coef_type C_N714 = -CW'(coef_q(714, FB));
   localparam coef_type C_1770 = CW'(coef_q(1770, FB));
   localparam coef_type C_ONE  = CW'(longint'(1) << FB);
   // gray weights are in 1/256, scaled up to the common fraction
   localparam coef_type C_G76  = CW'(longint'(76) << (FB - 8));
   localparam coef_type C_G150 = CW'(longint'(150) << (FB - 8));
   localparam coef_type C_G30  = CW'(longint'(30) << (FB - 8));
   localparam sum_type  BIAS   = SW'(longint'(128) << FB);

   // mode register
   mode_type mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RGB2YUV;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // stage handshake: each stage loads when empty or when it drains
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready   = !rsp_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_tvalid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) rsp_valid_ff <= s2_valid_ff;
      end
   end

   // stage 1: input register
   logic [31:0] s1_pixel_ff;
   logic        s1_last_ff;

   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) begin
         s1_pixel_ff <= req_tdata;
         s1_last_ff  <= req_tlast;
      end
   end

   // stage 2: operand and coefficient selection, nine products
   // coef[c][k] weighs operand k into output byte c
   logic signed [8:0] op      [3];
   coef_type          coef    [3][3];
   sum_type           bias_in [3];
   sum_type           prod_in [3][3];
   sum_type           op_ext;
   sum_type           coef_ext;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         op[k] = $signed({1'b0, s1_pixel_ff[8*k +: 8]});
      end
      for (int c = 0; c < 3; c++) begin
         bias_in[c] = '0;
         for (int k = 0; k < 3; k++) begin
            coef[c][k] = '0;
         end
      end
      case (mode_ff)
         MODE_RGB2YUV: begin
            // byte 2 y, byte 1 u, byte 0 v; operands r, g, b
            coef[2][0] = C_299;  coef[2][1] = C_587;  coef[2][2] = C_114;
            coef[1][0] = C_N169; coef[1][1] = C_N331; coef[1][2] = C_500;
            coef[0][0] = C_500;  coef[0][1] = C_N419; coef[0][2] = C_N081;
            bias_in[1] = BIAS;
            bias_in[0] = BIAS;
         end
         MODE_YUV2RGB: begin
            // operands v-128, u-128, y; byte 0 r, byte 1 g, byte 2 b
            op[0] = op[0] - 9'sd128;
            op[1] = op[1] - 9'sd128;
            coef[0][0] = C_1403; coef[0][2] = C_ONE;
            coef[1][0] = C_N714; coef[1][1] = C_N343; coef[1][2] = C_ONE;
            coef[2][1] = C_1770; coef[2][2] = C_ONE;
         end
         MODE_RGB2GRAY: begin
            // upper channels sum to zero and clamp to zero
            coef[0][0] = C_G76;  coef[0][1] = C_G150; coef[0][2] = C_G30;
         end
         default: begin
            // replicate bypasses the arithmetic
         end
      endcase
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < 3; k++) begin
            op_ext        = SW'(op[k]);
            coef_ext      = SW'(coef[c][k]);
            prod_in[c][k] = op_ext * coef_ext;
         end
      end
   end

   sum_type    s2_prod_ff [3][3];
   sum_type    s2_bias_ff [3];
   logic [7:0] s2_alpha_ff;
   logic [7:0] s2_byte0_ff;
   logic       s2_last_ff;
   mode_type   s2_mode_ff;

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_prod_ff  <= prod_in;
         s2_bias_ff  <= bias_in;
         s2_alpha_ff <= s1_pixel_ff[31:24];
         s2_byte0_ff <= s1_pixel_ff[7:0];
         s2_last_ff  <= s1_last_ff;
         s2_mode_ff  <= mode_ff;
      end
   end

   // stage 3: channel sums, drop fraction, clamp to 0..255, pack
   sum_type     sum    [3];
   sum_type     quo    [3];
   logic [7:0]  chan   [3];
   logic [31:0] rsp_tdata_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = s2_bias_ff[c] + s2_prod_ff[c][0] + s2_prod_ff[c][1] + s2_prod_ff[c][2];
         quo[c] = sum[c] >>> FB;
         if (sum[c][SW-1] || sum[c] == '0) begin
            chan[c] = 8'd0;
         end else if (|quo[c][SW-1:8]) begin
            chan[c] = 8'hFF;
         end else begin
            chan[c] = quo[c][7:0];
         end
      end
      case (s2_mode_ff)
         MODE_RGB2YUV, MODE_YUV2RGB: rsp_tdata_in = {s2_alpha_ff, chan[2], chan[1], chan[0]};
         MODE_RGB2GRAY:              rsp_tdata_in = {24'd0, chan[0]};
         default:                    rsp_tdata_in = {4{s2_byte0_ff}};
      endcase
   end

   logic [31:0] rsp_tdata_ff;
   logic        rsp_tlast_ff;

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tlast_ff <= s2_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

### hdl/pcsc_checker.sv
// ----------------------------------------------------------------------------
// pcsc_checker
// port-level checks for the pixel color space converter, bound to the top
// ----------------------------------------------------------------------------
`include "pixel_color_space_converter_unit_assert.svh"

module pcsc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [31:0]        rsp_tdata,
   input logic               rsp_tlast
);
   // pixels accepted but not yet delivered
   logic [2:0] inflight_ff;
   logic [2:0] inflight_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_beat && !rsp_beat) inflight_in = inflight_ff + 3'd1;
      if (rsp_beat && !req_beat) inflight_in = inflight_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `PCSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `PCSC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   `PCSC_ASSERT_SAME(a_empty_accepts, clock, reset, !rsp_tvalid, req_tready)
   `PCSC_ASSERT_SAME(a_no_invented, clock, reset, rsp_tvalid, inflight_ff != 3'd0)
   `PCSC_ASSERT_SAME(a_depth, clock, reset, 1'b1, inflight_ff <= 3'd3)

endmodule

bind pixel_color_space_converter_unit pcsc_checker u_pcsc_checker (.*);
